/* src/rtss_pkg.sv */
// ----------------------------------------------------------------------------
// rtss_pkg
// Shared codes and string helpers for the record table.
// ----------------------------------------------------------------------------
package rtss_pkg;

  localparam int unsigned STR_BITS = 256;

  localparam logic [2:0] CMD_PUSH      = 3'd0;
  localparam logic [2:0] CMD_REMOVE    = 3'd1;
  localparam logic [2:0] CMD_SORT_NAME = 3'd2;
  localparam logic [2:0] CMD_SORT_TYPE = 3'd3;
  localparam logic [2:0] CMD_SORT_PRI  = 3'd4;
  localparam logic [2:0] CMD_SEARCH    = 3'd5;
  localparam logic [2:0] CMD_READ      = 3'd6;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_FULL       = 3'd1;
  localparam logic [2:0] ST_NOT_FOUND  = 3'd2;
  localparam logic [2:0] ST_UNSORTED   = 3'd3;
  localparam logic [2:0] ST_BAD_INDEX  = 3'd4;

  // zero every byte from the first zero byte on, and beyond chars
  function automatic logic [STR_BITS-1:0] canon(input logic [STR_BITS-1:0] v,
                                                input int unsigned chars);
    logic [STR_BITS-1:0] r;
    logic alive;
    r = '0;
    alive = 1'b1;
    for (int k = 0; k < STR_BITS / 8; k++) begin
      alive = alive && (v[k*8 +: 8] != 8'd0) && (k < chars);
      r[k*8 +: 8] = alive ? v[k*8 +: 8] : 8'd0;
    end
    return r;
  endfunction

  function automatic logic [7:0] fold(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
  endfunction

endpackage

/* src/rtss_ram.sv */
// ----------------------------------------------------------------------------
// rtss_ram
// Generic RAM, one write port, one read port, registered read (read-first).
// ----------------------------------------------------------------------------
module rtss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

endmodule

/* src/rtss_cmp.sv */
// ----------------------------------------------------------------------------
// rtss_cmp
// Case-insensitive string compare of two zero-padded strings.
// ----------------------------------------------------------------------------
module rtss_cmp #(
  parameter int CHARS = 32
) (
  input  logic [CHARS*8-1:0] a,
  input  logic [CHARS*8-1:0] b,
  output logic               lt,
  output logic               gt
);
  import rtss_pkg::*;

  logic [CHARS*8-1:0] fa;
  logic [CHARS*8-1:0] fb;

  // byte 0 goes to the top so a plain magnitude compare is lexicographic
  always_comb begin
    for (int k = 0; k < CHARS; k++) begin
      fa[(CHARS-1-k)*8 +: 8] = fold(a[k*8 +: 8]);
      fb[(CHARS-1-k)*8 +: 8] = fold(b[k*8 +: 8]);
    end
  end

  assign lt = fa < fb;
  assign gt = fa > fb;

endmodule

/* src/record_table_sort_search.sv */
// ----------------------------------------------------------------------------
// record_table_sort_search
// Record table with append, remove, three sorts, binary search and read.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; busy stays high
// until the result, which is shown for one cycle with done high and cannot
// be stalled. All records live in one RAM with one read and one write port,
// and that read port sets the pace: remove scans for the name, then shifts
// each later record down; name sort runs bubble passes, type sort is an
// insertion sort, priority sort is a selection sort, highest priority first,
// that swaps records; search is a binary search over the name-sorted table.
module record_table_sort_search #(
  parameter int DEPTH      = 32,
  parameter int NAME_CHARS = 32,
  parameter int TYPE_CHARS = 24
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  cmd,
  input  logic [63:0] name_0,
  input  logic [63:0] name_1,
  input  logic [63:0] name_2,
  input  logic [63:0] name_3,
  input  logic [63:0] type_0,
  input  logic [63:0] type_1,
  input  logic [63:0] type_2,
  input  logic [3:0]  priority_req,
  input  logic [4:0]  read_index,
  output logic        done,
  output logic [2:0]  status,
  output logic [4:0]  position,
  output logic [8:0]  comparisons,
  output logic [5:0]  entry_total,
  output logic [63:0] out_name_0,
  output logic [63:0] out_name_1,
  output logic [63:0] out_name_2,
  output logic [63:0] out_name_3,
  output logic [63:0] out_type_0,
  output logic [63:0] out_type_1,
  output logic [63:0] out_type_2,
  output logic [3:0]  out_priority
);
  import rtss_pkg::*;

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int NB = NAME_CHARS * 8;
  localparam int TB = TYPE_CHARS * 8;
  localparam int W  = NB + TB + 4;

  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_EXEC     = 5'd1;
  localparam logic [4:0] S_RD_OUT   = 5'd2;
  localparam logic [4:0] S_RM_CMP   = 5'd3;
  localparam logic [4:0] S_CP_RD    = 5'd4;
  localparam logic [4:0] S_CP_WR    = 5'd5;
  localparam logic [4:0] S_BS_LOADA = 5'd6;
  localparam logic [4:0] S_BS_CMP   = 5'd7;
  localparam logic [4:0] S_BS_END   = 5'd8;
  localparam logic [4:0] S_IS_KEY   = 5'd9;
  localparam logic [4:0] S_IS_CMP   = 5'd10;
  localparam logic [4:0] S_IS_PUT   = 5'd11;
  localparam logic [4:0] S_SS_FIRST = 5'd12;
  localparam logic [4:0] S_SS_SCAN  = 5'd13;
  localparam logic [4:0] S_SS_SW0   = 5'd14;
  localparam logic [4:0] S_SS_SW1   = 5'd15;
  localparam logic [4:0] S_SS_SW2   = 5'd16;
  localparam logic [4:0] S_SS_SW3   = 5'd17;
  localparam logic [4:0] S_SS_NEXT  = 5'd18;
  localparam logic [4:0] S_BN_ISSUE = 5'd19;
  localparam logic [4:0] S_BN_CMP   = 5'd20;

  logic [4:0]    state, state_next;
  logic [CW-1:0] count, count_next;
  logic          sorted, sorted_next;
  logic          done_next;
  logic [2:0]    cmd_r, cmd_r_next;
  logic [4:0]    idx_r, idx_r_next;
  logic [W-1:0]  a_rec, a_rec_next;
  logic [CW-1:0] i, i_next;
  logic [CW-1:0] j, j_next;
  logic [CW-1:0] m, m_next;
  logic [CW-1:0] lim, lim_next;
  logic [CW-1:0] lo, lo_next;
  logic [CW-1:0] hi, hi_next;
  logic [3:0]    mp, mp_next;
  logic          swapped, swapped_next;
  logic [8:0]    cmp_cnt, cmp_cnt_next;
  logic [2:0]    status_r, status_r_next;
  logic [CW-1:0] pos_r, pos_r_next;
  logic [W-1:0]  rd_rec, rd_rec_next;

  logic          we;
  logic [IW-1:0] waddr;
  logic [W-1:0]  wdata;
  logic [IW-1:0] raddr;
  logic [W-1:0]  rdata;

  logic [STR_BITS-1:0] nm_c;
  logic [STR_BITS-1:0] ty_c;
  logic [W-1:0]        in_rec;
  logic [NB-1:0]       rd_name, a_name;
  logic [TB-1:0]       rd_type, a_type;
  logic [3:0]          rd_pri;
  logic                lt_n, gt_n, lt_t, gt_t;
  logic [CW-1:0]       mid;
  logic [8:0]          cnt_inc;
  logic [IW+4:0]       idx_ext;
  logic [STR_BITS-1:0] out_nm_w;
  logic [191:0]        out_ty_w;

  assign nm_c = canon({name_3, name_2, name_1, name_0}, NAME_CHARS);
  assign ty_c = canon({64'd0, type_2, type_1, type_0}, TYPE_CHARS);
  assign in_rec = {nm_c[NB-1:0], ty_c[TB-1:0], priority_req};

  assign rd_name = rdata[W-1 -: NB];
  assign rd_type = rdata[TB+3:4];
  assign rd_pri  = rdata[3:0];
  assign a_name  = a_rec[W-1 -: NB];
  assign a_type  = a_rec[TB+3:4];

  assign mid     = lo + ((hi - lo - 1'b1) >> 1);
  assign cnt_inc = (cmp_cnt == 9'd511) ? cmp_cnt : cmp_cnt + 9'd1;
  assign idx_ext = {{IW{1'b0}}, idx_r};

  rtss_ram #(.WIDTH(W), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // rdata against stored key: lt means record sorts before key
  rtss_cmp #(.CHARS(NAME_CHARS)) u_cmp_name (
    .a  (rd_name),
    .b  (a_name),
    .lt (lt_n),
    .gt (gt_n)
  );

  rtss_cmp #(.CHARS(TYPE_CHARS)) u_cmp_type (
    .a  (rd_type),
    .b  (a_type),
    .lt (lt_t),
    .gt (gt_t)
  );

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next    = state;
    count_next    = count;
    sorted_next   = sorted;
    done_next     = 1'b0;
    cmd_r_next    = cmd_r;
    idx_r_next    = idx_r;
    a_rec_next    = a_rec;
    i_next        = i;
    j_next        = j;
    m_next        = m;
    lim_next      = lim;
    lo_next       = lo;
    hi_next       = hi;
    mp_next       = mp;
    swapped_next  = swapped;
    cmp_cnt_next  = cmp_cnt;
    status_r_next = status_r;
    pos_r_next    = pos_r;
    rd_rec_next   = rd_rec;
    we            = 1'b0;
    waddr         = '0;
    wdata         = a_rec;
    raddr         = '0;

    case (state)
      S_IDLE: begin
        if (start) begin
          cmd_r_next    = cmd;
          idx_r_next    = read_index;
          a_rec_next    = in_rec;
          cmp_cnt_next  = '0;
          status_r_next = ST_OK;
          pos_r_next    = '0;
          rd_rec_next   = '0;
          state_next    = S_EXEC;
        end
      end

      S_EXEC: begin
        case (cmd_r)
          CMD_PUSH: begin
            if (count >= CW'(DEPTH)) begin
              status_r_next = ST_FULL;
            end else begin
              we          = 1'b1;
              waddr       = count[IW-1:0];
              count_next  = count + 1'b1;
              sorted_next = 1'b0;
            end
            state_next = S_IDLE;
            done_next  = 1'b1;
          end
          CMD_REMOVE: begin
            if (count == '0) begin
              status_r_next = ST_NOT_FOUND;
              state_next    = S_IDLE;
              done_next     = 1'b1;
            end else begin
              i_next     = '0;
              state_next = S_RM_CMP;
            end
          end
          CMD_SORT_NAME: begin
            sorted_next = 1'b1;
            if (count < CW'(2)) begin
              state_next = S_IDLE;
              done_next  = 1'b1;
            end else begin
              lim_next     = count;
              j_next       = '0;
              swapped_next = 1'b0;
              state_next   = S_BS_LOADA;
            end
          end
          CMD_SORT_TYPE: begin
            sorted_next = 1'b0;
            if (count < CW'(2)) begin
              state_next = S_IDLE;
              done_next  = 1'b1;
            end else begin
              i_next     = CW'(1);
              raddr      = IW'(1);
              state_next = S_IS_KEY;
            end
          end
          CMD_SORT_PRI: begin
            sorted_next = 1'b0;
            if (count < CW'(2)) begin
              state_next = S_IDLE;
              done_next  = 1'b1;
            end else begin
              i_next     = '0;
              state_next = S_SS_FIRST;
            end
          end
          CMD_SEARCH: begin
            if (!sorted) begin
              status_r_next = ST_UNSORTED;
              state_next    = S_IDLE;
              done_next     = 1'b1;
            end else begin
              lo_next       = '0;
              hi_next       = count;
              status_r_next = ST_NOT_FOUND;
              state_next    = S_BN_ISSUE;
            end
          end
          CMD_READ: begin
            if (32'(idx_r) >= 32'(count)) begin
              status_r_next = ST_BAD_INDEX;
              state_next    = S_IDLE;
              done_next     = 1'b1;
            end else begin
              raddr      = idx_ext[IW-1:0];
              state_next = S_RD_OUT;
            end
          end
          default: begin
            state_next = S_IDLE;
            done_next  = 1'b1;
          end
        endcase
      end

      S_RD_OUT: begin
        rd_rec_next = rdata;
        state_next  = S_IDLE;
        done_next   = 1'b1;
      end

      S_RM_CMP: begin
        if (rd_name == a_name) begin
          j_next     = i;
          state_next = S_CP_RD;
        end else if ({1'b0, i} + 1'b1 < {1'b0, count}) begin
          i_next = i + 1'b1;
          raddr  = i_next[IW-1:0];
        end else begin
          status_r_next = ST_NOT_FOUND;
          state_next    = S_IDLE;
          done_next     = 1'b1;
        end
      end

      S_CP_RD: begin
        if ({1'b0, j} + 1'b1 < {1'b0, count}) begin
          j_next     = j + 1'b1;
          raddr      = j_next[IW-1:0];
          j_next     = j;
          state_next = S_CP_WR;
        end else begin
          count_next  = count - 1'b1;
          sorted_next = 1'b0;
          state_next  = S_IDLE;
          done_next   = 1'b1;
        end
      end

      S_CP_WR: begin
        we         = 1'b1;
        waddr      = j[IW-1:0];
        wdata      = rdata;
        j_next     = j + 1'b1;
        state_next = S_CP_RD;
      end

      S_BS_LOADA: begin
        a_rec_next = rdata;
        raddr      = IW'(1);
        state_next = S_BS_CMP;
      end

      S_BS_CMP: begin
        cmp_cnt_next = cnt_inc;
        we           = 1'b1;
        waddr        = j[IW-1:0];
        if (lt_n) begin
          wdata        = rdata;
          swapped_next = 1'b1;
        end else begin
          wdata      = a_rec;
          a_rec_next = rdata;
        end
        j_next = j + 1'b1;
        if ({1'b0, j} + 2'd2 < {1'b0, lim}) begin
          i_next = j + 2'd2;
          raddr  = i_next[IW-1:0];
        end else begin
          state_next = S_BS_END;
        end
      end

      S_BS_END: begin
        we    = 1'b1;
        waddr = j[IW-1:0];
        wdata = a_rec;
        if (!swapped || lim < CW'(3)) begin
          state_next = S_IDLE;
          done_next  = 1'b1;
        end else begin
          lim_next     = lim - 1'b1;
          j_next       = '0;
          swapped_next = 1'b0;
          state_next   = S_BS_LOADA;
        end
      end

      S_IS_KEY: begin
        a_rec_next = rdata;
        j_next     = i;
        m_next     = i - 1'b1;
        raddr      = m_next[IW-1:0];
        state_next = S_IS_CMP;
      end

      S_IS_CMP: begin
        cmp_cnt_next = cnt_inc;
        if (gt_t && !lt_t) begin
          we     = 1'b1;
          waddr  = j[IW-1:0];
          wdata  = rdata;
          j_next = j - 1'b1;
          if (j > CW'(1)) begin
            m_next = j - 2'd2;
            raddr  = m_next[IW-1:0];
          end else begin
            state_next = S_IS_PUT;
          end
        end else begin
          state_next = S_IS_PUT;
        end
      end

      S_IS_PUT: begin
        we     = 1'b1;
        waddr  = j[IW-1:0];
        wdata  = a_rec;
        i_next = i + 1'b1;
        if ({1'b0, i} + 1'b1 < {1'b0, count}) begin
          raddr      = i_next[IW-1:0];
          state_next = S_IS_KEY;
        end else begin
          state_next = S_IDLE;
          done_next  = 1'b1;
        end
      end

      S_SS_FIRST: begin
        mp_next    = rd_pri;
        m_next     = i;
        j_next     = i + 1'b1;
        raddr      = j_next[IW-1:0];
        state_next = S_SS_SCAN;
      end

      S_SS_SCAN: begin
        cmp_cnt_next = cnt_inc;
        if (rd_pri > mp) begin
          mp_next = rd_pri;
          m_next  = j;
        end
        if ({1'b0, j} + 1'b1 < {1'b0, count}) begin
          j_next = j + 1'b1;
          raddr  = j_next[IW-1:0];
        end else begin
          state_next = S_SS_SW0;
        end
      end

      S_SS_SW0: begin
        if (m == i) begin
          state_next = S_SS_NEXT;
        end else begin
          raddr      = i[IW-1:0];
          state_next = S_SS_SW1;
        end
      end

      S_SS_SW1: begin
        a_rec_next = rdata;
        raddr      = m[IW-1:0];
        state_next = S_SS_SW2;
      end

      S_SS_SW2: begin
        we         = 1'b1;
        waddr      = i[IW-1:0];
        wdata      = rdata;
        state_next = S_SS_SW3;
      end

      S_SS_SW3: begin
        we         = 1'b1;
        waddr      = m[IW-1:0];
        wdata      = a_rec;
        state_next = S_SS_NEXT;
      end

      S_SS_NEXT: begin
        i_next = i + 1'b1;
        if ({1'b0, i} + 2'd2 < {1'b0, count}) begin
          raddr      = i_next[IW-1:0];
          state_next = S_SS_FIRST;
        end else begin
          state_next = S_IDLE;
          done_next  = 1'b1;
        end
      end

      S_BN_ISSUE: begin
        if (lo < hi) begin
          m_next     = mid;
          raddr      = mid[IW-1:0];
          state_next = S_BN_CMP;
        end else begin
          state_next = S_IDLE;
          done_next  = 1'b1;
        end
      end

      S_BN_CMP: begin
        cmp_cnt_next = cnt_inc;
        if (lt_n) begin
          lo_next    = m + 1'b1;
          state_next = S_BN_ISSUE;
        end else if (gt_n) begin
          hi_next    = m;
          state_next = S_BN_ISSUE;
        end else begin
          status_r_next = ST_OK;
          pos_r_next    = m;
          state_next    = S_IDLE;
          done_next     = 1'b1;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      count  <= '0;
      sorted <= 1'b0;
      done   <= 1'b0;
    end else begin
      state  <= state_next;
      count  <= count_next;
      sorted <= sorted_next;
      done   <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r    <= cmd_r_next;
    idx_r    <= idx_r_next;
    a_rec    <= a_rec_next;
    i        <= i_next;
    j        <= j_next;
    m        <= m_next;
    lim      <= lim_next;
    lo       <= lo_next;
    hi       <= hi_next;
    mp       <= mp_next;
    swapped  <= swapped_next;
    cmp_cnt  <= cmp_cnt_next;
    status_r <= status_r_next;
    pos_r    <= pos_r_next;
    rd_rec   <= rd_rec_next;
  end

  assign out_nm_w = STR_BITS'(rd_rec[W-1 -: NB]);
  assign out_ty_w = 192'(rd_rec[TB+3:4]);

  assign status       = status_r;
  assign position     = 5'(pos_r);
  assign comparisons  = cmp_cnt;
  assign entry_total  = 6'(count);
  assign out_name_0   = out_nm_w[63:0];
  assign out_name_1   = out_nm_w[127:64];
  assign out_name_2   = out_nm_w[191:128];
  assign out_name_3   = out_nm_w[255:192];
  assign out_type_0   = out_ty_w[63:0];
  assign out_type_1   = out_ty_w[127:64];
  assign out_type_2   = out_ty_w[191:128];
  assign out_priority = rd_rec[3:0];

endmodule
